[src/page_table_walk_translate_defines.svh]
// assertion macros shared by the page table walker rtl
`ifndef PAGE_TABLE_WALK_TRANSLATE_DEFINES_SVH
`define PAGE_TABLE_WALK_TRANSLATE_DEFINES_SVH
`ifndef SYNTHESIS
// plain property checked on every edge outside reset
`define PTWT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same-cycle implication
`define PTWT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PTWT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PTWT_ASSERT(label, prop, msg)
`define PTWT_ASSERT_IMP(label, ante, cons, msg)
`define PTWT_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

[src/ptwt_pkg.sv]
// types, constants and helpers for the four-level page table walker
package ptwt_pkg;

  // physical address width actually decoded from entries and root
  localparam int PHYS_ADDR_BITS = 52;

  // field widths
  localparam int ADDR_W  = 52;
  localparam int VA_W    = 48;
  localparam int ENTRY_W = 64;
  localparam int IDX_W   = 9;

  // frame bits of a physical address or an entry
  localparam logic [ADDR_W-1:0] PHYS_MASK =
    (ADDR_W'(1) << PHYS_ADDR_BITS) - ADDR_W'(1);
  localparam logic [ADDR_W-1:0] FRAME_MASK = PHYS_MASK & ~ADDR_W'(12'hFFF);

  // page offsets
  localparam logic [VA_W-1:0] OFF_1G = 48'h0000_3FFF_FFFF;
  localparam logic [VA_W-1:0] OFF_2M = 48'h0000_001F_FFFF;
  localparam logic [VA_W-1:0] OFF_4K = 48'h0000_0000_0FFF;

  // index positions in the virtual address
  localparam int SHIFT_PML4 = 39;
  localparam int SHIFT_PDPT = 30;
  localparam int SHIFT_PD   = 21;
  localparam int SHIFT_PT   = 12;

  // entry bits
  localparam int BIT_PRESENT = 0;
  localparam int BIT_PS      = 7;

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_ENTRY = 1'b1;

  // result kinds
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // page size codes
  localparam logic [1:0] PS_4K = 2'd0;
  localparam logic [1:0] PS_2M = 2'd1;
  localparam logic [1:0] PS_1G = 2'd2;

  // level whose entry is awaited
  typedef enum logic [1:0] {
    LVL_PML4 = 2'd0,
    LVL_PDPT = 2'd1,
    LVL_PD   = 2'd2,
    LVL_PT   = 2'd3
  } level_t;

  // walk control state
  typedef struct packed {
    logic   busy;
    level_t level;
  } walk_t;

  // one result beat
  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [ADDR_W-1:0] address;
    logic              present;
    logic [1:0]        leaf_size;
  } result_t;

  // table index of a virtual address at a level
  function automatic logic [IDX_W-1:0] table_index(logic [VA_W-1:0] va, level_t lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      LVL_PML4: idx = va[SHIFT_PML4 +: IDX_W];
      LVL_PDPT: idx = va[SHIFT_PDPT +: IDX_W];
      LVL_PD:   idx = va[SHIFT_PD +: IDX_W];
      LVL_PT:   idx = va[SHIFT_PT +: IDX_W];
      default:  idx = '0;
    endcase
    return idx;
  endfunction

  // entry address inside a table
  function automatic logic [ADDR_W-1:0] entry_addr(logic [ADDR_W-1:0] base,
                                                   logic [IDX_W-1:0] idx);
    return (base & FRAME_MASK) | ADDR_W'({idx, 3'b000});
  endfunction

endpackage

[src/ptwt_step.sv]
// decode of one walker beat: next request or final translation and walk state update
module ptwt_step (
  input  logic                          cmd,
  input  logic [ptwt_pkg::VA_W-1:0]     virt_addr,
  input  logic [ptwt_pkg::ENTRY_W-1:0]  entry_data,
  input  logic [ptwt_pkg::ADDR_W-1:0]   root_base,
  input  ptwt_pkg::walk_t               walk,
  input  logic [ptwt_pkg::VA_W-1:0]     saved_vaddr,
  output ptwt_pkg::result_t             res,
  output ptwt_pkg::walk_t               walk_nxt,
  output logic                          load_vaddr
);

  logic [ptwt_pkg::ADDR_W-1:0] frame;
  logic                        ps;
  ptwt_pkg::level_t            lvl_up;

  // entry fields
  assign frame  = entry_data[ptwt_pkg::ADDR_W-1:0] & ptwt_pkg::FRAME_MASK;
  assign ps     = entry_data[ptwt_pkg::BIT_PS];
  assign lvl_up = ptwt_pkg::level_t'(walk.level + 2'd1);

  // walk decision
  always_comb begin
    res        = '0;
    walk_nxt   = walk;
    load_vaddr = 1'b0;
    if (cmd == ptwt_pkg::CMD_START) begin
      if (!walk.busy) begin
        load_vaddr     = 1'b1;
        walk_nxt.busy  = 1'b1;
        walk_nxt.level = ptwt_pkg::LVL_PML4;
        res.valid      = 1'b1;
        res.kind       = ptwt_pkg::KIND_READ;
        res.address    = ptwt_pkg::entry_addr(root_base,
                           ptwt_pkg::table_index(virt_addr, ptwt_pkg::LVL_PML4));
      end
    end else if (walk.busy) begin
      res.valid = 1'b1;
      if (!entry_data[ptwt_pkg::BIT_PRESENT]) begin
        // not-present fault
        walk_nxt      = '0;
        res.kind      = ptwt_pkg::KIND_DONE;
      end else if (walk.level == ptwt_pkg::LVL_PDPT && ps) begin
        walk_nxt      = '0;
        res.kind      = ptwt_pkg::KIND_DONE;
        res.present   = 1'b1;
        res.leaf_size = ptwt_pkg::PS_1G;
        res.address   = frame | ptwt_pkg::ADDR_W'(saved_vaddr & ptwt_pkg::OFF_1G);
      end else if (walk.level == ptwt_pkg::LVL_PD && ps) begin
        walk_nxt      = '0;
        res.kind      = ptwt_pkg::KIND_DONE;
        res.present   = 1'b1;
        res.leaf_size = ptwt_pkg::PS_2M;
        res.address   = frame | ptwt_pkg::ADDR_W'(saved_vaddr & ptwt_pkg::OFF_2M);
      end else if (walk.level == ptwt_pkg::LVL_PT) begin
        walk_nxt      = '0;
        res.kind      = ptwt_pkg::KIND_DONE;
        res.present   = 1'b1;
        res.leaf_size = ptwt_pkg::PS_4K;
        res.address   = frame | ptwt_pkg::ADDR_W'(saved_vaddr & ptwt_pkg::OFF_4K);
      end else begin
        // follow the table pointer one level down
        walk_nxt.level = lvl_up;
        res.kind       = ptwt_pkg::KIND_READ;
        res.address    = ptwt_pkg::entry_addr(frame,
                           ptwt_pkg::table_index(saved_vaddr, lvl_up));
      end
    end
  end

endmodule

[src/page_table_walk_translate.sv]
// top level of the four-level page table walker
//
// in channel: each beat is either a translate command (in_tuser = 0, virtual
// address in in_tdata) or an entry read back from memory (in_tuser = 1, the
// 64-bit entry in the upper part of in_tdata). out channel: each beat is a
// read request for the next table entry (out_tuser = 0) or the finished
// translation (out_tuser = 1) with physical address, present flag and page
// size. A translate while a walk is open and an entry beat while idle are
// dropped without a result.
// cfg_we/cfg_wdata load the root table base; write it only while idle.
// an input beat passes the input register, then decode into the result
// register. throughput: one beat per cycle while out_tready does not stall,
// set by the single decode stage between the two registers.
// reset (rst_n low, synchronous) empties both registers, ends any walk and
// clears the root base. when out_tready is low the result register holds its
// beat; the input register still takes a beat that produces no result, and
// in_tready drops once a result-bearing beat waits behind the held one.
module page_table_walk_translate (
  input  logic         clk,
  input  logic         rst_n,
  // input channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,  // virt_addr[47:0], entry_data[111:48]
  input  logic         in_tuser,  // command
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [55:0]  out_tdata, // address[51:0], present[52], leaf_size[54:53], zero
  output logic         out_tuser, // result_kind
  // configuration
  input  logic         cfg_we,
  input  logic [51:0]  cfg_wdata  // root_table_base
);

`include "page_table_walk_translate_defines.svh"

  // input register
  logic                         s1_valid_r;
  logic                         s1_cmd_r;
  logic [ptwt_pkg::VA_W-1:0]    s1_vaddr_r;
  logic [ptwt_pkg::ENTRY_W-1:0] s1_entry_r;

  // walk state and configuration
  ptwt_pkg::walk_t              walk_r;
  ptwt_pkg::walk_t              walk_nxt;
  logic [ptwt_pkg::VA_W-1:0]    vaddr_r;
  logic [ptwt_pkg::ADDR_W-1:0]  root_r;

  // result register
  ptwt_pkg::result_t            out_r;
  ptwt_pkg::result_t            res;

  logic load_vaddr;
  logic s1_go;
  logic in_take;

  ptwt_step u_step (
    .cmd         (s1_cmd_r),
    .virt_addr   (s1_vaddr_r),
    .entry_data  (s1_entry_r),
    .root_base   (root_r),
    .walk        (walk_r),
    .saved_vaddr (vaddr_r),
    .res         (res),
    .walk_nxt    (walk_nxt),
    .load_vaddr  (load_vaddr)
  );

  // stage handshake: a beat moves on if its result has a free slot or it has none
  assign s1_go     = s1_valid_r && (!out_r.valid || out_tready || !res.valid);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_take   = in_tvalid && in_tready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_take) begin
      s1_cmd_r   <= in_tuser;
      s1_vaddr_r <= in_tdata[ptwt_pkg::VA_W-1:0];
      s1_entry_r <= in_tdata[ptwt_pkg::VA_W +: ptwt_pkg::ENTRY_W];
    end
  end

  // walk state and root base
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r  <= '0;
      vaddr_r <= '0;
      root_r  <= '0;
    end else begin
      if (s1_go) begin
        walk_r <= walk_nxt;
        if (load_vaddr) begin
          vaddr_r <= s1_vaddr_r;
        end
      end
      if (cfg_we) begin
        root_r <= cfg_wdata;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (s1_go && res.valid) begin
      out_r <= res;
    end else if (out_tready) begin
      out_r.valid <= 1'b0;
    end
  end

  assign out_tvalid = out_r.valid;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {1'b0, out_r.leaf_size, out_r.present, out_r.address};

  // checks
  `PTWT_ASSERT_IMP(a_req_clean, out_r.valid && out_r.kind == ptwt_pkg::KIND_READ,
    !out_r.present && out_r.leaf_size == ptwt_pkg::PS_4K, "read request with leaf info")
  `PTWT_ASSERT_IMP(a_fault_zero,
    out_r.valid && out_r.kind == ptwt_pkg::KIND_DONE && !out_r.present,
    out_r.address == '0 && out_r.leaf_size == ptwt_pkg::PS_4K, "fault with nonzero payload")
  `PTWT_ASSERT_NXT(a_done_idle, s1_go && res.valid && res.kind == ptwt_pkg::KIND_DONE,
    !walk_r.busy && walk_r.level == ptwt_pkg::LVL_PML4, "walk still open after completion")
  `PTWT_ASSERT(a_level_busy, walk_r.busy || walk_r.level == ptwt_pkg::LVL_PML4,
    "idle walker with nonzero level")
  `PTWT_ASSERT_IMP(a_size_code, out_r.valid,
    out_r.leaf_size != 2'd3, "invalid page size code")

endmodule

[sim/page_table_walk_translate_test.sv]
// testbench for the four-level page table walker: directed walks, then random walks
module page_table_walk_translate_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 500000;
  localparam int SETTLE_CYCLES = 4;

  // one expected or observed result beat
  typedef struct packed {
    logic                        kind;
    logic [ptwt_pkg::ADDR_W-1:0] addr;
    logic                        present;
    logic [1:0]                  size;
  } walk_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;  // virt_addr[47:0], entry_data[111:48]
  logic         in_tuser = 1'b0; // command
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [55:0]  out_tdata;      // address[51:0], present[52], leaf_size[54:53], zero
  logic         out_tuser;      // result_kind
  logic         cfg_we = 1'b0;
  logic [51:0]  cfg_wdata = '0; // root_table_base

  // walker shadow state
  logic [ptwt_pkg::ADDR_W-1:0] root_base = '0;
  logic                        walker_busy = 1'b0;
  ptwt_pkg::level_t            walker_level = ptwt_pkg::LVL_PML4;
  logic [ptwt_pkg::VA_W-1:0]   walker_va = '0;

  walk_result_t awaited_results[$];
  int fail_count = 0;
  int in_gap_max = 18;
  int out_stall_max = 18;

  page_table_walk_translate i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int draw_wait(int max);
    if (max == 0) return 0;
    return $urandom_range(0, max);
  endfunction

  function void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // advance the shadow walker by one accepted beat; returns 1 when a result is due
  function bit predict_walk_step(input logic cmd, input logic [ptwt_pkg::VA_W-1:0] va,
                                 input logic [ptwt_pkg::ENTRY_W-1:0] entry,
                                 output walk_result_t res);
    logic [ptwt_pkg::ADDR_W-1:0] frame;
    logic [ptwt_pkg::IDX_W-1:0]  idx;
    ptwt_pkg::level_t            next_level;
    res = '0;
    // translate command: dropped while a walk is open
    if (cmd == ptwt_pkg::CMD_START) begin
      if (walker_busy) return 1'b0;
      walker_va = va;
      walker_busy = 1'b1;
      walker_level = ptwt_pkg::LVL_PML4;
      res.kind = ptwt_pkg::KIND_READ;
      res.addr = {root_base[ptwt_pkg::ADDR_W-1:12], 12'h000} | {40'b0, va[47:39], 3'b000};
      return 1'b1;
    end
    // stray entry with no walk open
    if (!walker_busy) return 1'b0;
    res.kind = ptwt_pkg::KIND_DONE;
    // not present ends the walk with a fault
    if (!entry[ptwt_pkg::BIT_PRESENT]) begin
      walker_busy = 1'b0;
      walker_level = ptwt_pkg::LVL_PML4;
      return 1'b1;
    end
    frame = {entry[ptwt_pkg::ADDR_W-1:12], 12'h000};
    // leaves: huge pages need the size bit, the last level never does
    if (walker_level == ptwt_pkg::LVL_PDPT && entry[ptwt_pkg::BIT_PS]) begin
      res.addr = frame | {22'b0, walker_va[29:0]};
      res.size = ptwt_pkg::PS_1G;
    end else if (walker_level == ptwt_pkg::LVL_PD && entry[ptwt_pkg::BIT_PS]) begin
      res.addr = frame | {31'b0, walker_va[20:0]};
      res.size = ptwt_pkg::PS_2M;
    end else if (walker_level == ptwt_pkg::LVL_PT) begin
      res.addr = frame | {40'b0, walker_va[11:0]};
      res.size = ptwt_pkg::PS_4K;
    end else begin
      // table pointer: ask for the next level's entry
      next_level = ptwt_pkg::level_t'(walker_level + 1);
      case (next_level)
        ptwt_pkg::LVL_PDPT: idx = walker_va[38:30];
        ptwt_pkg::LVL_PD:   idx = walker_va[29:21];
        default:            idx = walker_va[20:12];
      endcase
      walker_level = next_level;
      res.kind = ptwt_pkg::KIND_READ;
      res.addr = frame | {40'b0, idx, 3'b000};
      return 1'b1;
    end
    res.present = 1'b1;
    walker_busy = 1'b0;
    walker_level = ptwt_pkg::LVL_PML4;
    return 1'b1;
  endfunction

  // send one beat after a random gap, predict on acceptance
  task automatic send_beat(input logic cmd, input logic [ptwt_pkg::VA_W-1:0] va,
                           input logic [ptwt_pkg::ENTRY_W-1:0] entry);
    int gap;
    bit has_result;
    walk_result_t res;
    gap = draw_wait(in_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {entry, va};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    has_result = predict_walk_step(cmd, va, entry, res);
    if (has_result) awaited_results.push_back(res);
  endtask

  // drain all results, then let the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_root(input logic [ptwt_pkg::ADDR_W-1:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    root_base = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // result side stalls a random number of cycles before each beat
  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_wait(out_stall_max);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(negedge clk);
      while (!out_tvalid) @(negedge clk);
      @(posedge clk);
    end
  end

  // compare each taken result beat with the oldest prediction
  always @(negedge clk) begin
    walk_result_t got;
    walk_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser;
      got.addr = out_tdata[51:0];
      got.present = out_tdata[52];
      got.size = out_tdata[54:53];
      if (awaited_results.size() == 0) begin
        note_failure($sformatf("unexpected result kind=%0d addr=%h present=%0d size=%0d",
                               got.kind, got.addr, got.present, got.size));
      end else begin
        want = awaited_results.pop_front();
        if (got.kind != want.kind || got.addr != want.addr ||
            got.present != want.present || got.size != want.size) begin
          note_failure({$sformatf("mismatch: exp kind=%0d addr=%h present=%0d size=%0d, ",
                                  want.kind, want.addr, want.present, want.size),
                        $sformatf("got kind=%0d addr=%h present=%0d size=%0d",
                                  got.kind, got.addr, got.present, got.size)});
        end
      end
    end
  end

  // full walk to a 4 KB leaf from the reset root, size bit ignored at top and bottom
  task automatic test_leaf_4k();
    send_beat(ptwt_pkg::CMD_START, 48'hFFFF_FFFF_FFFF, '0);
    send_beat(ptwt_pkg::CMD_ENTRY, '0, 64'hFFF0_0000_1234_5081);
    send_beat(ptwt_pkg::CMD_ENTRY, '0, 64'h0000_0ABC_DEF0_1003);
    send_beat(ptwt_pkg::CMD_ENTRY, '0, 64'h8000_0001_2345_6001);
    send_beat(ptwt_pkg::CMD_ENTRY, '0, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  // 1 GB leaf with frame bits inside the offset and a 2 MB leaf, unaligned root
  task automatic test_huge_leaves();
    write_root(52'hF_FFFF_FFFF_FFFF);
    send_beat(ptwt_pkg::CMD_START, 48'h0000_0000_0000, '0);
    send_beat(ptwt_pkg::CMD_ENTRY, '0, 64'h0000_0000_0000_2001);
    send_beat(ptwt_pkg::CMD_ENTRY, '0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(ptwt_pkg::CMD_START, 48'h1234_5678_9ABC, '0);
    send_beat(ptwt_pkg::CMD_ENTRY, '0, 64'h0000_0000_0000_3001);
    send_beat(ptwt_pkg::CMD_ENTRY, '0, 64'h0000_0000_0000_4001);
    send_beat(ptwt_pkg::CMD_ENTRY, '0, 64'h0007_FFFF_FFE0_0081);
  endtask

  // not-present entries at the top level and in a directory
  task automatic test_faults();
    send_beat(ptwt_pkg::CMD_START, 48'h8000_0000_0000, '0);
    send_beat(ptwt_pkg::CMD_ENTRY, '0, 64'h0);
    send_beat(ptwt_pkg::CMD_START, 48'h7FFF_FFFF_FFFF, '0);
    send_beat(ptwt_pkg::CMD_ENTRY, '0, 64'h0000_0000_0000_5001);
    send_beat(ptwt_pkg::CMD_ENTRY, '0, 64'h0000_0000_0000_6001);
    send_beat(ptwt_pkg::CMD_ENTRY, '0, 64'hFFFF_FFFF_FFFF_FFFE);
  endtask

  // entry while idle and translate while busy are both dropped
  task automatic test_dropped_beats();
    send_beat(ptwt_pkg::CMD_ENTRY, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(ptwt_pkg::CMD_START, 48'h0000_DEAD_BEEF, '0);
    send_beat(ptwt_pkg::CMD_START, 48'hFFFF_0000_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(ptwt_pkg::CMD_ENTRY, '0, 64'h0);
  endtask

  // random complete walks with stray entries and dropped translates mixed in
  task automatic test_random_walks(input int count,
                                   input logic [ptwt_pkg::ADDR_W-1:0] root,
                                   input int gap_max, input int stall_max);
    int sent;
    logic [63:0] bits;
    logic [ptwt_pkg::VA_W-1:0] va;
    logic [ptwt_pkg::ENTRY_W-1:0] entry;
    write_root(root);
    in_gap_max = gap_max;
    out_stall_max = stall_max;
    sent = 0;
    while (sent < count) begin
      // stray entry with no walk open
      if ($urandom_range(0, 99) < 8) begin
        bits = rand64();
        send_beat(ptwt_pkg::CMD_ENTRY, bits[ptwt_pkg::VA_W-1:0], rand64());
      end
      bits = rand64();
      case ($urandom_range(0, 9))
        0: va = '0;
        1: va = '1;
        default: va = bits[ptwt_pkg::VA_W-1:0];
      endcase
      send_beat(ptwt_pkg::CMD_START, va, rand64());
      sent++;
      while (walker_busy) begin
        if ($urandom_range(0, 99) < 5) begin
          bits = rand64();
          send_beat(ptwt_pkg::CMD_START, bits[ptwt_pkg::VA_W-1:0], rand64());
        end
        entry = rand64();
        entry[ptwt_pkg::BIT_PRESENT] = ($urandom_range(0, 9) != 0);
        entry[ptwt_pkg::BIT_PS] = ($urandom_range(0, 9) < 4);
        bits = rand64();
        send_beat(ptwt_pkg::CMD_ENTRY, bits[ptwt_pkg::VA_W-1:0], entry);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_leaf_4k();
    test_huge_leaves();
    test_faults();
    test_dropped_beats();
    test_random_walks(250, 52'h0, 18, 18);
    test_random_walks(250, 52'hF_FFFF_FFFF_FFFF, 0, 0);
    test_random_walks(250, 52'(rand64()), 18, 0);
    test_random_walks(250, 52'(rand64()), 0, 18);
    settle();
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[page_table_walk_translate.f]
+incdir+src
src/ptwt_pkg.sv
src/ptwt_step.sv
src/page_table_walk_translate.sv
sim/page_table_walk_translate_test.sv
